// ===== hw/rtl/pclb_pkg.sv =====
// Shared types, codes and defaults of the particle cell list binner.
package pclb_pkg;

  localparam int COORD_W = 23;
  localparam int POS_W   = 24;
  localparam int GRID_W  = 7;
  localparam int PID_W   = 16;

  localparam int DEF_MAX_COLUMNS    = 64;
  localparam int DEF_MAX_ROWS       = 64;
  localparam int DEF_SLOTS_PER_CELL = 16;
  localparam int DEF_BUCKET_SLOTS   = 64;
  localparam int DEF_ID_BITS        = 16;

  localparam logic [COORD_W-1:0] RST_AREA_WIDTH  = 23'd16384;
  localparam logic [COORD_W-1:0] RST_AREA_HEIGHT = 23'd16384;
  localparam logic [COORD_W-1:0] RST_CELL_SIZE   = 23'd256;
  localparam logic [GRID_W-1:0]  RST_CELLS       = 7'd64;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_MOVE   = 3'd2,
    OP_NEIGH  = 3'd3,
    OP_SIZE   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_AREA_WIDTH   = 3'd0,
    REG_AREA_HEIGHT  = 3'd1,
    REG_CELL_SIZE    = 3'd2,
    REG_CELLS_ACROSS = 3'd3,
    REG_CELLS_DOWN   = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOC, S_DIV, S_FILL, S_FILLW, S_INS,
    S_SRD, S_SCMP, S_SHRD, S_SHWR, S_POST, S_EMIT, S_NEIGH
  } state_e;

  typedef enum logic [1:0] {
    OFF_MINUS, OFF_SAME, OFF_PLUS
  } off_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] cell_index;
    logic        is_oob_bucket;
    logic        cell_valid;
    logic [16:0] in_bounds_total;
    logic [6:0]  oob_total;
    logic        last;
  } res_t;

  // Column offset of each neighbour in output order.
  function automatic off_e nb_dc(input logic [2:0] i);
    off_e o;
    unique case (i)
      3'd0, 3'd1, 3'd2: o = OFF_MINUS;
      3'd3, 3'd4:       o = OFF_SAME;
      default:          o = OFF_PLUS;
    endcase
    return o;
  endfunction

  // Row offset of each neighbour in output order.
  function automatic off_e nb_dr(input logic [2:0] i);
    off_e o;
    unique case (i)
      3'd0, 3'd3, 3'd7: o = OFF_MINUS;
      3'd1, 3'd6:       o = OFF_SAME;
      default:          o = OFF_PLUS;
    endcase
    return o;
  endfunction

endpackage

// ===== hw/rtl/pclb_if.sv =====
// Handshake channel interfaces for requests and results.
interface pclb_in_if;
  import pclb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [2:0]              opcode;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    pos_nan;
  logic signed [POS_W-1:0] dest_x;
  logic signed [POS_W-1:0] dest_y;
  logic                    dest_nan;
  logic [PID_W-1:0]        particle_id;

  modport source (output valid, opcode, pos_x, pos_y, pos_nan, dest_x, dest_y, dest_nan,
                  particle_id, input ready);
  modport sink (input valid, opcode, pos_x, pos_y, pos_nan, dest_x, dest_y, dest_nan,
                particle_id, output ready);
endinterface

interface pclb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] cell_index;
  logic        is_oob_bucket;
  logic        cell_valid;
  logic [16:0] in_bounds_total;
  logic [6:0]  oob_total;
  logic        last;

  modport source (output valid, status, cell_index, is_oob_bucket, cell_valid,
                  in_bounds_total, oob_total, last, input ready);
  modport sink (input valid, status, cell_index, is_oob_bucket, cell_valid,
                in_bounds_total, oob_total, last, output ready);
endinterface

// ===== hw/rtl/particle_cell_list_binner_unit.sv =====
// Particle cell list binner: grid cells plus out-of-bounds bucket in on-chip memories.
// The block bins particle ids into a 2D grid of square cells plus one out-of-bounds bucket
// and handles one request at a time. Every request that touches a cell first divides both
// coordinates by the cell size in two serial dividers that run side by side, then reads
// the cell's fill count from memory. A neighbour query lists its cells at one result per
// cycle while the receiver takes them. Remove searches the slots for the id and shifts
// each slot behind the removed id down by one, since the slot memory has a single read
// and a single write port; a move is a remove followed by an insert. After reset the block
// clears the fill counts of all MAX_COLUMNS*MAX_ROWS cells (4096 by default) before it
// takes its first request; configuration writes are taken during that pass.
module particle_cell_list_binner_unit import pclb_pkg::*; #(
  parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS       = DEF_MAX_ROWS,
  parameter int SLOTS_PER_CELL = DEF_SLOTS_PER_CELL,
  parameter int BUCKET_SLOTS   = DEF_BUCKET_SLOTS,
  parameter int ID_BITS        = DEF_ID_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [COORD_W-1:0] cfg_wdata_i,
  pclb_in_if.sink            in_if,
  pclb_out_if.source         out_if
);

  localparam int NCELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int NSLOTS = NCELLS * SLOTS_PER_CELL;
  localparam int CW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ECW    = $clog2(MAX_COLUMNS + 1);
  localparam int ERW    = $clog2(MAX_ROWS + 1);
  localparam int KW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int SAW    = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int BAW    = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int FW     = $clog2(SLOTS_PER_CELL + 1);
  localparam int BFW    = $clog2(BUCKET_SLOTS + 1);
  localparam int GW     = $clog2(NSLOTS + 1);
  localparam int NW     = (FW > BFW) ? FW : BFW;

  // Configuration registers.
  logic [COORD_W-1:0] area_w_q, area_h_q, cell_size_q;
  logic [GRID_W-1:0]  cells_across_q, cells_down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_w_q       <= RST_AREA_WIDTH;
      area_h_q       <= RST_AREA_HEIGHT;
      cell_size_q    <= RST_CELL_SIZE;
      cells_across_q <= RST_CELLS;
      cells_down_q   <= RST_CELLS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AREA_WIDTH:   area_w_q       <= cfg_wdata_i;
        REG_AREA_HEIGHT:  area_h_q       <= cfg_wdata_i;
        REG_CELL_SIZE:    cell_size_q    <= cfg_wdata_i;
        REG_CELLS_ACROSS: cells_across_q <= cfg_wdata_i[GRID_W-1:0];
        REG_CELLS_DOWN:   cells_down_q   <= cfg_wdata_i[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid dimensions limited to what the memories hold, with zero taken as one.
  logic [ECW-1:0] eff_cols, cmax;
  logic [ERW-1:0] eff_rows, rmax;

  always_comb begin
    if (cells_across_q == '0) begin
      eff_cols = ECW'(1);
    end else if (32'(cells_across_q) > MAX_COLUMNS) begin
      eff_cols = ECW'(MAX_COLUMNS);
    end else begin
      eff_cols = ECW'(cells_across_q);
    end
    if (cells_down_q == '0) begin
      eff_rows = ERW'(1);
    end else if (32'(cells_down_q) > MAX_ROWS) begin
      eff_rows = ERW'(MAX_ROWS);
    end else begin
      eff_rows = ERW'(cells_down_q);
    end
    cmax = eff_cols - 1'b1;
    rmax = eff_rows - 1'b1;
  end

  // Latched request.
  op_e                     op_q;
  logic signed [POS_W-1:0] px_q, py_q, dx_q, dy_q;
  logic                    pn_q, dn_q;
  logic [ID_BITS-1:0]      id_q;
  logic                    accept;

  assign accept = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_e'(in_if.opcode);
      px_q <= in_if.pos_x;
      py_q <= in_if.pos_y;
      pn_q <= in_if.pos_nan;
      dx_q <= in_if.dest_x;
      dy_q <= in_if.dest_y;
      dn_q <= in_if.dest_nan;
      id_q <= ID_BITS'(in_if.particle_id);
    end
  end

  // Sequencer state.
  state_e            state_q, state_d;
  logic [KW-1:0]     clr_q, clr_d;
  logic              phase_ins_q, phase_ins_d;
  logic              oob_q, oob_d;
  logic [CW-1:0]     c_q, c_d;
  logic [RW-1:0]     r_q, r_d;
  logic [NW-1:0]     n_q, n_d, idx_q, idx_d;
  logic [1:0]        st_q, st_d;
  logic [7:0]        nbm_q, nbm_d;
  logic [BFW-1:0]    bfill_q, bfill_d;
  logic [GW-1:0]     gcount_q, gcount_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  // Location of the current phase's position.
  logic                    use_dest, loc_nan, loc_oob;
  logic signed [POS_W-1:0] loc_x, loc_y;
  logic [COORD_W-1:0]      divisor, qx, qy;
  logic                    div_start, div_done, div_done_y;

  always_comb begin
    use_dest = (op_q == OP_MOVE) && phase_ins_q;
    loc_x    = use_dest ? dx_q : px_q;
    loc_y    = use_dest ? dy_q : py_q;
    loc_nan  = use_dest ? dn_q : pn_q;
    loc_oob  = loc_nan || loc_x[POS_W-1] || loc_y[POS_W-1] ||
               (loc_x[COORD_W-1:0] > area_w_q) || (loc_y[COORD_W-1:0] > area_h_q);
    divisor  = (cell_size_q == '0) ? COORD_W'(1) : cell_size_q;
  end

  pclb_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (loc_x[COORD_W-1:0]),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (qx)
  );

  pclb_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (loc_y[COORD_W-1:0]),
    .divisor_i  (divisor),
    .done_o     (div_done_y),
    .quotient_o (qy)
  );

  // Memories: per-cell fill counts, cell slots and bucket slots.
  logic [FW-1:0]      fill_mem [NCELLS];
  logic [ID_BITS-1:0] slot_mem [NSLOTS];
  logic [ID_BITS-1:0] bkt_mem  [BUCKET_SLOTS];

  logic               fill_we, fill_re, slot_we, slot_re, bkt_we, bkt_re;
  logic [KW-1:0]      fill_waddr, k_w;
  logic [FW-1:0]      fill_wdata, fill_rdata_q;
  logic [NW-1:0]      ridx, widx;
  logic [SAW-1:0]     slot_raddr, slot_waddr;
  logic [ID_BITS-1:0] slot_wdata, slot_rdata_q, bkt_rdata_q, rd_data;

  assign k_w        = KW'(32'(c_q) * MAX_ROWS + 32'(r_q));
  assign slot_raddr = SAW'(32'(k_w) * SLOTS_PER_CELL + 32'(ridx));
  assign slot_waddr = SAW'(32'(k_w) * SLOTS_PER_CELL + 32'(widx));
  assign rd_data    = oob_q ? bkt_rdata_q : slot_rdata_q;

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (fill_re) fill_rdata_q <= fill_mem[k_w];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rdata_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) bkt_mem[BAW'(widx)] <= slot_wdata;
    if (bkt_re) bkt_rdata_q <= bkt_mem[BAW'(ridx)];
  end

  // Neighbour selection.
  logic       c_lo, c_hi, r_lo, r_hi, ok_c, ok_r;
  logic [7:0] nb_mask, nb_rest;
  logic [2:0] sel;
  logic [31:0] nc, nr;

  always_comb begin
    c_lo = (c_q != '0);
    r_lo = (r_q != '0);
    c_hi = (32'(c_q) + 32'd1) < 32'(eff_cols);
    r_hi = (32'(r_q) + 32'd1) < 32'(eff_rows);
    for (int i = 0; i < 8; i++) begin
      ok_c = (nb_dc(3'(i)) == OFF_MINUS) ? c_lo : (nb_dc(3'(i)) == OFF_PLUS) ? c_hi : 1'b1;
      ok_r = (nb_dr(3'(i)) == OFF_MINUS) ? r_lo : (nb_dr(3'(i)) == OFF_PLUS) ? r_hi : 1'b1;
      nb_mask[i] = ok_c && ok_r;
    end
    sel = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (nbm_q[b]) sel = 3'(b);
    end
    nb_rest = nbm_q & ~(8'd1 << sel);
    case (nb_dc(sel))
      OFF_MINUS: nc = 32'(c_q) - 32'd1;
      OFF_PLUS:  nc = 32'(c_q) + 32'd1;
      default:   nc = 32'(c_q);
    endcase
    case (nb_dr(sel))
      OFF_MINUS: nr = 32'(r_q) - 32'd1;
      OFF_PLUS:  nr = 32'(r_q) + 32'd1;
      default:   nr = 32'(r_q);
    endcase
  end

  logic out_free, full, match, rd_more, sh_more;

  always_comb begin
    out_free = !out_valid_q || out_if.ready;
    full     = oob_q ? (32'(n_q) >= BUCKET_SLOTS) : (32'(n_q) >= SLOTS_PER_CELL);
    match    = (rd_data == id_q);
    rd_more  = (idx_q < n_q);
    sh_more  = ((32'(idx_q) + 32'd1) < 32'(n_q));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == KW'(NCELLS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_if.valid) begin
          if (in_if.opcode == OP_INSERT || in_if.opcode == OP_REMOVE ||
              in_if.opcode == OP_MOVE || in_if.opcode == OP_NEIGH) begin
            state_d = S_LOC;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_LOC:   state_d = S_DIV;
      S_DIV:   if (div_done && div_done_y) state_d = S_FILL;
      S_FILL:  state_d = S_FILLW;
      S_FILLW: begin
        if (op_q == OP_NEIGH) state_d = S_NEIGH;
        else if (phase_ins_q) state_d = S_INS;
        else state_d = S_SRD;
      end
      S_INS:   state_d = S_EMIT;
      S_SRD:   state_d = rd_more ? S_SCMP : S_POST;
      S_SCMP:  state_d = match ? S_SHRD : S_SRD;
      S_SHRD:  state_d = sh_more ? S_SHWR : S_POST;
      S_SHWR:  state_d = S_SHRD;
      S_POST:  state_d = (op_q == OP_MOVE) ? S_LOC : S_EMIT;
      S_EMIT:  if (out_free) state_d = S_IDLE;
      S_NEIGH: begin
        if (out_free && (oob_q || nbm_q == '0 || nb_rest == '0)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    clr_d       = clr_q;
    phase_ins_d = phase_ins_q;
    oob_d       = oob_q;
    c_d         = c_q;
    r_d         = r_q;
    n_d         = n_q;
    idx_d       = idx_q;
    st_d        = st_q;
    nbm_d       = nbm_q;
    bfill_d     = bfill_q;
    gcount_d    = gcount_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    in_if.ready = 1'b0;
    div_start   = 1'b0;
    fill_we     = 1'b0;
    fill_re     = 1'b0;
    fill_waddr  = k_w;
    fill_wdata  = '0;
    slot_we     = 1'b0;
    slot_re     = 1'b0;
    bkt_we      = 1'b0;
    bkt_re      = 1'b0;
    ridx        = idx_q;
    widx        = idx_q;
    slot_wdata  = rd_data;

    if (out_valid_q && out_if.ready) out_valid_d = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
      end
      S_IDLE: begin
        in_if.ready = 1'b1;
        st_d        = ST_OK;
        phase_ins_d = (in_if.opcode == OP_INSERT);
      end
      S_LOC: begin
        div_start = 1'b1;
        oob_d     = loc_oob;
      end
      S_DIV: begin
        if (div_done && div_done_y) begin
          c_d = (32'(qx) > 32'(cmax)) ? CW'(cmax) : CW'(qx);
          r_d = (32'(qy) > 32'(rmax)) ? RW'(rmax) : RW'(qy);
        end
      end
      S_FILL: fill_re = 1'b1;
      S_FILLW: begin
        n_d   = oob_q ? NW'(bfill_q) : NW'(fill_rdata_q);
        idx_d = '0;
        nbm_d = nb_mask;
      end
      S_INS: begin
        widx       = n_q;
        slot_wdata = id_q;
        if (full) begin
          st_d = ST_FULL;
        end else if (oob_q) begin
          bkt_we  = 1'b1;
          bfill_d = bfill_q + 1'b1;
        end else begin
          slot_we    = 1'b1;
          fill_we    = 1'b1;
          fill_wdata = FW'(n_q + 1'b1);
          gcount_d   = gcount_q + 1'b1;
        end
      end
      S_SRD: begin
        if (rd_more) begin
          slot_re = !oob_q;
          bkt_re  = oob_q;
        end else begin
          st_d = ST_NOT_FOUND;
        end
      end
      S_SCMP: if (!match) idx_d = idx_q + 1'b1;
      S_SHRD: begin
        ridx = idx_q + 1'b1;
        if (sh_more) begin
          slot_re = !oob_q;
          bkt_re  = oob_q;
        end else if (oob_q) begin
          bfill_d = bfill_q - 1'b1;
        end else begin
          fill_we    = 1'b1;
          fill_wdata = FW'(n_q - 1'b1);
          gcount_d   = gcount_q - 1'b1;
        end
      end
      S_SHWR: begin
        // Close the gap: the next slot moves down by one.
        slot_we = !oob_q;
        bkt_we  = oob_q;
        idx_d   = idx_q + 1'b1;
      end
      S_POST: if (op_q == OP_MOVE) phase_ins_d = 1'b1;
      S_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          res_d.status          = st_q;
          res_d.cell_index      = '0;
          res_d.is_oob_bucket   = 1'b0;
          res_d.cell_valid      = 1'b0;
          res_d.in_bounds_total = 17'(gcount_q);
          res_d.oob_total       = 7'(bfill_q);
          res_d.last            = 1'b1;
        end
      end
      S_NEIGH: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          res_d.status          = ST_OK;
          res_d.in_bounds_total = 17'(gcount_q);
          res_d.oob_total       = 7'(bfill_q);
          if (oob_q) begin
            res_d.cell_index    = '0;
            res_d.is_oob_bucket = 1'b1;
            res_d.cell_valid    = 1'b1;
            res_d.last          = 1'b1;
          end else if (nbm_q == '0) begin
            res_d.cell_index    = '0;
            res_d.is_oob_bucket = 1'b0;
            res_d.cell_valid    = 1'b0;
            res_d.last          = 1'b1;
          end else begin
            res_d.cell_index    = 12'(nc * 32'(eff_rows) + nr);
            res_d.is_oob_bucket = 1'b0;
            res_d.cell_valid    = 1'b1;
            res_d.last          = (nb_rest == '0);
            nbm_d               = nb_rest;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      phase_ins_q <= 1'b0;
      oob_q       <= 1'b0;
      bfill_q     <= '0;
      gcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      phase_ins_q <= phase_ins_d;
      oob_q       <= oob_d;
      bfill_q     <= bfill_d;
      gcount_q    <= gcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q   <= c_d;
    r_q   <= r_d;
    n_q   <= n_d;
    idx_q <= idx_d;
    st_q  <= st_d;
    nbm_q <= nbm_d;
    res_q <= res_d;
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.status          = res_q.status;
  assign out_if.cell_index      = res_q.cell_index;
  assign out_if.is_oob_bucket   = res_q.is_oob_bucket;
  assign out_if.cell_valid      = res_q.cell_valid;
  assign out_if.in_bounds_total = res_q.in_bounds_total;
  assign out_if.oob_total       = res_q.oob_total;
  assign out_if.last            = res_q.last;

endmodule

// ===== hw/rtl/pclb_div.sv =====
// Restoring divider, one quotient bit per cycle, for coordinate over cell size.
module pclb_div import pclb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COORD_W-1:0] dividend_i,
  input  logic [COORD_W-1:0] divisor_i,
  output logic               done_o,
  output logic [COORD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(COORD_W + 1);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [COORD_W:0] rem_q, rem_d, rem_sh;
  logic [COORD_W-1:0] quo_q, quo_d, dvs_q, dvs_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q[COORD_W-1:0], quo_q[COORD_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(COORD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        quo_d = {quo_q[COORD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[COORD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the particle cell list binner with a built-in predictor.
`timescale 1ns / 1ps

module testbench;
  import pclb_pkg::*;

  localparam int CELL_CAP   = DEF_SLOTS_PER_CELL;
  localparam int BUCKET_CAP = DEF_BUCKET_SLOTS;
  localparam int ROW_STRIDE = DEF_MAX_ROWS;
  localparam int STALL_LIMIT = 30000;

  typedef struct {
    logic [2:0]              opcode;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic                    pnan;
    logic signed [POS_W-1:0] dx;
    logic signed [POS_W-1:0] dy;
    logic                    dnan;
    logic [PID_W-1:0]        id;
  } bin_req_t;

  typedef struct {
    logic [PID_W-1:0]        id;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    nan;
  } resident_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [COORD_W-1:0] cfg_wdata_i;

  pclb_in_if  req_ch ();
  pclb_out_if res_ch ();

  particle_cell_list_binner_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (req_ch),
    .out_if     (res_ch)
  );

  // Predictor copy of the configuration and occupancy.
  logic [COORD_W-1:0] area_w, area_h, cell_len;
  logic [GRID_W-1:0]  cols_reg, rows_reg;
  logic [PID_W-1:0]   cell_ids [DEF_MAX_COLUMNS*DEF_MAX_ROWS][$];
  logic [PID_W-1:0]   bucket_ids [$];
  logic [16:0]        grid_total;

  res_t      pending_results [$];
  resident_t residents [$];

  int  errors;
  int  n_sent;
  int  n_results;
  bit  idle_en;
  bit  stall_en;
  bit  hold_req;
  int  quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int eff_cols();
    return (cols_reg > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : ((cols_reg == 0) ? 1 : int'(cols_reg));
  endfunction

  function automatic int eff_rows();
    return (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : ((rows_reg == 0) ? 1 : int'(rows_reg));
  endfunction

  // Returns 1 when the position falls into the out-of-bounds bucket.
  function automatic bit find_cell(input logic signed [POS_W-1:0] x,
                                   input logic signed [POS_W-1:0] y, input logic nan,
                                   output int col, output int row);
    int step;
    col = 0;
    row = 0;
    step = (cell_len == 0) ? 1 : int'(cell_len);
    if (nan || x < 0 || y < 0 || int'(x) > int'(area_w) || int'(y) > int'(area_h)) return 1'b1;
    col = int'(x) / step;
    row = int'(y) / step;
    if (col > eff_cols() - 1) col = eff_cols() - 1;
    if (row > eff_rows() - 1) row = eff_rows() - 1;
    return 1'b0;
  endfunction

  function automatic status_e place_id(input logic signed [POS_W-1:0] x,
                                       input logic signed [POS_W-1:0] y, input logic nan,
                                       input logic [PID_W-1:0] id);
    int c, r, k;
    if (find_cell(x, y, nan, c, r)) begin
      if (bucket_ids.size() >= BUCKET_CAP) return ST_FULL;
      bucket_ids = {bucket_ids, id};
      return ST_OK;
    end
    k = c * ROW_STRIDE + r;
    if (cell_ids[k].size() >= CELL_CAP) return ST_FULL;
    cell_ids[k] = {cell_ids[k], id};
    grid_total++;
    return ST_OK;
  endfunction

  function automatic status_e take_id(input logic signed [POS_W-1:0] x,
                                      input logic signed [POS_W-1:0] y, input logic nan,
                                      input logic [PID_W-1:0] id);
    int c, r, k;
    if (find_cell(x, y, nan, c, r)) begin
      foreach (bucket_ids[i]) if (bucket_ids[i] == id) begin
        bucket_ids.delete(i);
        return ST_OK;
      end
      return ST_NOT_FOUND;
    end
    k = c * ROW_STRIDE + r;
    for (int i = 0; i < cell_ids[k].size(); i++) begin
      if (cell_ids[k][i] == id) begin
        cell_ids[k].delete(i);
        grid_total--;
        return ST_OK;
      end
    end
    return ST_NOT_FOUND;
  endfunction

  function automatic res_t make_result(input logic [1:0] st, input int idx, input logic oob,
                                       input logic vld);
    res_t o;
    o.status          = st;
    o.cell_index      = idx[11:0];
    o.is_oob_bucket   = oob;
    o.cell_valid      = vld;
    o.in_bounds_total = grid_total;
    o.oob_total       = 7'(bucket_ids.size());
    o.last            = 1'b0;
    return o;
  endfunction

  // Applies one request to the predicted state and queues the results it causes.
  task automatic bin_and_predict(input bin_req_t q);
    res_t    outs [$];
    status_e rs, is;
    int      c, r, nc, nr;
    int      dc [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    int      dr [8] = '{-1, 0, 1, -1, 1, 1, 0, -1};
    case (q.opcode)
      OP_INSERT: outs = {outs, make_result(place_id(q.px, q.py, q.pnan, q.id), 0, 0, 0)};
      OP_REMOVE: outs = {outs, make_result(take_id(q.px, q.py, q.pnan, q.id), 0, 0, 0)};
      OP_MOVE: begin
        rs = take_id(q.px, q.py, q.pnan, q.id);
        is = place_id(q.dx, q.dy, q.dnan, q.id);
        outs = {outs, make_result((is != ST_OK) ? is : rs, 0, 0, 0)};
      end
      OP_NEIGH: begin
        if (find_cell(q.px, q.py, q.pnan, c, r)) begin
          outs = {outs, make_result(ST_OK, 0, 1, 1)};
        end else begin
          for (int i = 0; i < 8; i++) begin
            nc = c + dc[i];
            nr = r + dr[i];
            if (nc < 0 || nr < 0 || nc >= eff_cols() || nr >= eff_rows()) continue;
            outs = {outs, make_result(ST_OK, nc * eff_rows() + nr, 0, 1)};
          end
          if (outs.size() == 0) outs = {outs, make_result(ST_OK, 0, 0, 0)};
        end
      end
      default: outs = {outs, make_result(ST_OK, 0, 0, 0)};
    endcase
    outs[outs.size()-1].last = 1'b1;
    pending_results = {pending_results, outs};
  endtask

  // Drives one request from a falling edge and returns at the falling edge after its transfer.
  task automatic send_req(input bin_req_t q);
    if (idle_en && ($urandom % 5 == 0)) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    req_ch.valid       = 1'b1;
    req_ch.opcode      = q.opcode;
    req_ch.pos_x       = q.px;
    req_ch.pos_y       = q.py;
    req_ch.pos_nan     = q.pnan;
    req_ch.dest_x      = q.dx;
    req_ch.dest_y      = q.dy;
    req_ch.dest_nan    = q.dnan;
    req_ch.particle_id = q.id;
    do @(posedge clk_i); while (!req_ch.ready);
    bin_and_predict(q);
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic bin_req_t mk_req(input op_e op, input int px, input int py,
                                      input logic pn, input int id);
    bin_req_t q;
    q.opcode = op;
    q.px = px[POS_W-1:0];
    q.py = py[POS_W-1:0];
    q.pnan = pn;
    q.dx = '0;
    q.dy = '0;
    q.dnan = 1'b0;
    q.id = id[PID_W-1:0];
    return q;
  endfunction

  // Mostly positions inside the area, with the extent itself, nan and wild values mixed in.
  task automatic pick_pos(output logic signed [POS_W-1:0] x, output logic signed [POS_W-1:0] y,
                          output logic nan);
    int sel;
    sel = $urandom_range(0, 19);
    nan = (sel == 0);
    x = POS_W'($urandom_range(0, int'(area_w)));
    y = POS_W'($urandom_range(0, int'(area_h)));
    if (sel == 1 || sel == 2) begin
      x = POS_W'($urandom);
      y = POS_W'($urandom);
    end else if (sel == 3) begin
      x = POS_W'(area_w);
      y = POS_W'(area_h);
    end else if (sel == 4) begin
      x = POS_W'(-$urandom_range(1, 300));
    end
  endtask

  task automatic write_reg(input reg_e idx, input int value);
    cfg_idx_i   = idx;
    cfg_wdata_i = value[COORD_W-1:0];
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (idx)
      REG_AREA_WIDTH:   area_w   = value[COORD_W-1:0];
      REG_AREA_HEIGHT:  area_h   = value[COORD_W-1:0];
      REG_CELL_SIZE:    cell_len = value[COORD_W-1:0];
      REG_CELLS_ACROSS: cols_reg = value[GRID_W-1:0];
      default:          rows_reg = value[GRID_W-1:0];
    endcase
  endtask

  // Reconfigures only once the block has drained and finished any trailing work.
  task automatic set_grid(input int aw, input int ah, input int h, input int ca, input int cd);
    req_ch.valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (150) @(negedge clk_i);
    write_reg(REG_AREA_WIDTH, aw);
    write_reg(REG_AREA_HEIGHT, ah);
    write_reg(REG_CELL_SIZE, h);
    write_reg(REG_CELLS_ACROSS, ca);
    write_reg(REG_CELLS_DOWN, cd);
    residents.delete();
  endtask

  task automatic test_directed();
    bin_req_t q;
    send_req(mk_req(OP_INSERT, 0, 0, 0, 0));
    send_req(mk_req(OP_INSERT, 16384, 16384, 0, 16'hFFFF));
    send_req(mk_req(OP_INSERT, 8388607, 8388607, 0, 16'h1234));
    send_req(mk_req(OP_INSERT, -8388608, -8388608, 0, 16'h5555));
    send_req(mk_req(OP_INSERT, 100, 100, 1, 16'hAAAA));
    send_req(mk_req(OP_INSERT, 16385, 0, 0, 16'h0001));
    send_req(mk_req(OP_NEIGH, 0, 0, 0, 0));
    send_req(mk_req(OP_NEIGH, 16384, 16384, 0, 0));
    send_req(mk_req(OP_NEIGH, 1000, 1000, 0, 0));
    send_req(mk_req(OP_NEIGH, 0, 5000, 0, 0));
    send_req(mk_req(OP_NEIGH, -1, 5, 0, 0));
    send_req(mk_req(OP_NEIGH, 5, 5, 1, 0));
    send_req(mk_req(OP_REMOVE, 10, 20, 0, 0));
    send_req(mk_req(OP_REMOVE, 10, 20, 0, 0));
    send_req(mk_req(OP_REMOVE, 0, 0, 1, 16'hAAAA));
    q = mk_req(OP_MOVE, 16384, 16384, 0, 16'hFFFF);
    q.dx = 512;
    q.dy = 512;
    send_req(q);
    q = mk_req(OP_MOVE, 700, 700, 0, 16'h7777);
    q.dx = 700;
    q.dy = 700;
    send_req(q);
    q = mk_req(OP_MOVE, 700, 700, 0, 16'h7777);
    q.dnan = 1'b1;
    send_req(q);
    send_req(mk_req(OP_SIZE, 0, 0, 0, 0));
    for (int op = 5; op < 8; op++) begin
      q = mk_req(OP_SIZE, 1, 1, 0, 1);
      q.opcode = op[2:0];
      send_req(q);
    end
  endtask

  // Seventeen inserts into one cell: the last one finds it full.
  task automatic test_cell_overflow();
    for (int i = 0; i < CELL_CAP + 1; i++)
      send_req(mk_req(OP_INSERT, $urandom_range(256, 511), $urandom_range(0, 255), 0,
                      $urandom));
    send_req(mk_req(OP_REMOVE, 300, 10, 0, cell_ids[ROW_STRIDE][0]));
  endtask

  task automatic test_bucket_overflow();
    while (bucket_ids.size() < BUCKET_CAP)
      send_req(mk_req(OP_INSERT, -$urandom_range(1, 8388608), $urandom, 0, $urandom));
    send_req(mk_req(OP_INSERT, 0, 0, 1, 16'h4242));
    send_req(mk_req(OP_REMOVE, 0, 0, 1, bucket_ids[BUCKET_CAP/2]));
  endtask

  // The receiver holds off for a long stretch while neighbour queries keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send_req(mk_req(OP_NEIGH, $urandom_range(256, 15000), $urandom_range(256, 15000), 0, 0));
  endtask

  task automatic random_traffic(input int count);
    bin_req_t  q;
    resident_t rp;
    int        sel, pick;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      q.dnan = 1'b0;
      q.dx = '0;
      q.dy = '0;
      q.id = PID_W'($urandom);
      pick_pos(q.px, q.py, q.pnan);
      if (sel < 40) begin
        q.opcode = OP_INSERT;
        if (residents.size() < 300) begin
          rp.id = q.id;
          rp.x = q.px;
          rp.y = q.py;
          rp.nan = q.pnan;
          residents = {residents, rp};
        end
      end else if (sel < 70 && residents.size() > 0) begin
        pick = $urandom_range(0, residents.size() - 1);
        rp = residents[pick];
        residents.delete(pick);
        q.id = rp.id;
        q.px = rp.x;
        q.py = rp.y;
        q.pnan = rp.nan;
        if (sel < 55) begin
          q.opcode = OP_REMOVE;
        end else begin
          q.opcode = OP_MOVE;
          pick_pos(q.dx, q.dy, q.dnan);
          rp.x = q.dx;
          rp.y = q.dy;
          rp.nan = q.dnan;
          residents = {residents, rp};
        end
      end else if (sel < 88) begin
        q.opcode = OP_NEIGH;
      end else if (sel < 94) begin
        q.opcode = OP_SIZE;
      end else begin
        // Noise: every field random, unknown opcodes included.
        q.opcode = 3'($urandom);
        q.px = POS_W'($urandom);
        q.py = POS_W'($urandom);
        q.pnan = 1'($urandom);
        q.dx = POS_W'($urandom);
        q.dy = POS_W'($urandom);
        q.dnan = 1'($urandom);
      end
      send_req(q);
    end
  endtask

  task automatic test_grid_settings();
    set_grid(768, 768, 256, 3, 3);
    random_traffic(40);
    set_grid(8388607, 8388607, 8388607, 1, 1);
    send_req(mk_req(OP_NEIGH, 0, 0, 0, 0));
    random_traffic(25);
    set_grid(100, 5000, 1, 64, 64);
    random_traffic(35);
    set_grid(1, 1, 1, 1, 64);
    random_traffic(20);
    set_grid(16384, 9000, 300, 55, 31);
    random_traffic(35);
    // Final stretch without any idling on either side.
    idle_en  = 1'b0;
    stall_en = 1'b0;
    set_grid(4096, 4096, 64, 64, 64);
    random_traffic(30);
  endtask

  // Result side: random stalls plus the long hold-off when requested.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready = 1'b0;
      end else if (stall_en && rst_ni && ($urandom % 6 == 0)) begin
        stall_left = $urandom_range(1, 19) - 1;
        res_ch.ready = 1'b0;
      end else begin
        res_ch.ready = rst_ni;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d index=%0d", $time, res_ch.status,
                 res_ch.cell_index);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.status !== want.status || res_ch.cell_index !== want.cell_index ||
            res_ch.is_oob_bucket !== want.is_oob_bucket ||
            res_ch.cell_valid !== want.cell_valid ||
            res_ch.in_bounds_total !== want.in_bounds_total ||
            res_ch.oob_total !== want.oob_total || res_ch.last !== want.last) begin
          errors++;
          $display("%0t: mismatch expected st=%0d idx=%0d oob=%0b vld=%0b grid=%0d bkt=%0d last=%0b",
                   $time, want.status, want.cell_index, want.is_oob_bucket, want.cell_valid,
                   want.in_bounds_total, want.oob_total, want.last);
          $display("%0t:          actual   st=%0d idx=%0d oob=%0b vld=%0b grid=%0d bkt=%0d last=%0b",
                   $time, res_ch.status, res_ch.cell_index, res_ch.is_oob_bucket,
                   res_ch.cell_valid, res_ch.in_bounds_total, res_ch.oob_total, res_ch.last);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("particle_cell_list_binner_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    n_sent = 0;
    n_results = 0;
    quiet_cycles = 0;
    idle_en = 1'b1;
    stall_en = 1'b1;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_AREA_WIDTH;
    cfg_wdata_i = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_INSERT;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.pos_nan = 1'b0;
    req_ch.dest_x = '0;
    req_ch.dest_y = '0;
    req_ch.dest_nan = 1'b0;
    req_ch.particle_id = '0;
    area_w = RST_AREA_WIDTH;
    area_h = RST_AREA_HEIGHT;
    cell_len = RST_CELL_SIZE;
    cols_reg = RST_CELLS;
    rows_reg = RST_CELLS;
    grid_total = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_cell_overflow();
    test_bucket_overflow();
    test_backpressure();
    test_grid_settings();

    req_ch.valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d results under the default and six other grids,",
             n_sent, n_results);
    $display("including full cells, a full bucket, edge clamping and a long result stall.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("particle_cell_list_binner_unit verification clean");
    end else begin
      $display("particle_cell_list_binner_unit verification failed");
    end
    $finish;
  end

endmodule
